// File: sv/voxel_face_cull_ambient_occlusion_defines.svh
// ----------------------------------------------------------------------------
// Voxel face culling assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULL_AMBIENT_OCCLUSION_DEFINES_SVH
`define VOXEL_FACE_CULL_AMBIENT_OCCLUSION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFCAO_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VFCAO_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/vfcao_pkg.sv
// ----------------------------------------------------------------------------
// Voxel face culling package
// Beat types, register indexes, face directions and the neighbor bit tables
// used for per-vertex ambient occlusion.
// ----------------------------------------------------------------------------
package vfcao_pkg;

	// Configuration register indexes.
	localparam logic REG_AIR_TYPE   = 1'b0;
	localparam logic REG_WATER_TYPE = 1'b1;

	// Face directions.
	localparam logic [2:0] DIR_TOP    = 3'd0;
	localparam logic [2:0] DIR_BOTTOM = 3'd1;
	localparam logic [2:0] DIR_FRONT  = 3'd2;
	localparam logic [2:0] DIR_BACK   = 3'd3;
	localparam logic [2:0] DIR_RIGHT  = 3'd4;
	localparam logic [2:0] DIR_LEFT   = 3'd5;

	localparam int NUM_DIRS = 6;

	// Shade code used when both side neighbors of a vertex are solid.
	localparam logic [2:0] SHADE_BOTH_SIDES = 3'd4;

	// Bit index into the 3x3x3 solid mask.
	typedef logic [4:0] nbit_t;

	// Face neighbor bit per direction.
	localparam nbit_t NORM_BIT [NUM_DIRS] = '{5'd16, 5'd10, 5'd22, 5'd4, 5'd14, 5'd12};

	// Per direction and vertex: first side, second side and corner neighbor bits.
	localparam nbit_t SIDE_A_TAB [NUM_DIRS][4] = '{
		'{5'd15, 5'd17, 5'd17, 5'd15},
		'{5'd9,  5'd11, 5'd11, 5'd9},
		'{5'd21, 5'd23, 5'd23, 5'd21},
		'{5'd5,  5'd3,  5'd3,  5'd5},
		'{5'd23, 5'd5,  5'd5,  5'd23},
		'{5'd3,  5'd21, 5'd21, 5'd3}
	};
	localparam nbit_t SIDE_B_TAB [NUM_DIRS][4] = '{
		'{5'd25, 5'd25, 5'd7,  5'd7},
		'{5'd1,  5'd1,  5'd19, 5'd19},
		'{5'd19, 5'd19, 5'd25, 5'd25},
		'{5'd1,  5'd1,  5'd7,  5'd7},
		'{5'd11, 5'd11, 5'd17, 5'd17},
		'{5'd9,  5'd9,  5'd15, 5'd15}
	};
	localparam nbit_t CORNER_TAB [NUM_DIRS][4] = '{
		'{5'd24, 5'd26, 5'd8,  5'd6},
		'{5'd0,  5'd2,  5'd20, 5'd18},
		'{5'd18, 5'd20, 5'd26, 5'd24},
		'{5'd2,  5'd0,  5'd6,  5'd8},
		'{5'd20, 5'd2,  5'd8,  5'd26},
		'{5'd0,  5'd18, 5'd24, 5'd6}
	};

	// Input beat: one voxel.
	typedef struct packed {
		logic        first_of_chunk;
		logic [3:0]  pos_x;
		logic [5:0]  pos_y;
		logic [3:0]  pos_z;
		logic [7:0]  block_type;
		logic [26:0] solid_mask;
		logic [5:0]  air_mask;
	} voxel_t;

	// Output beat: one face.
	typedef struct packed {
		logic [3:0]  face_x;
		logic [5:0]  face_y;
		logic [3:0]  face_z;
		logic [2:0]  face_dir;
		logic        to_water_mesh;
		logic        use_side_color;
		logic [7:0]  face_type;
		logic [11:0] shade_codes;
		logic [15:0] base_index;
		logic        last_face;
	} face_t;

	// Classified voxel waiting between the front and back parts.
	typedef struct packed {
		logic        first_of_chunk;
		logic [3:0]  pos_x;
		logic [5:0]  pos_y;
		logic [3:0]  pos_z;
		logic [7:0]  block_type;
		logic        is_water;
		logic [5:0]  face_mask;
		logic [26:0] solid_mask;
	} entry_t;

	// Push side of the queue.
	typedef struct packed {
		logic   push;
		entry_t entry;
	} push_t;

	// Pop side status of the queue.
	typedef struct packed {
		logic   empty;
		entry_t head;
	} head_t;

	// Four 3-bit vertex shade codes of one face, vertex 0 in the low bits.
	function automatic logic [11:0] face_shades(input logic [26:0] mask,
		input logic [2:0] dir);
		logic       s1;
		logic       s2;
		logic       cn;
		logic [2:0] code;
		logic [11:0] codes;
		codes = '0;
		if (dir <= DIR_LEFT) begin
			for (int v = 0; v < 4; v++) begin
				s1 = mask[SIDE_A_TAB[dir][v]];
				s2 = mask[SIDE_B_TAB[dir][v]];
				cn = mask[CORNER_TAB[dir][v]];
				if (s1 && s2)
					code = SHADE_BOTH_SIDES;
				else
					code = 3'(s1) + 3'(s2) + 3'(cn);
				codes[3*v +: 3] = code;
			end
		end
		return codes;
	endfunction

endpackage

// File: sv/vfcao_front.sv
// ----------------------------------------------------------------------------
// Voxel classifier
// Holds the type registers, sorts each voxel into air, water or solid and
// works out which of its six faces are visible.
// ----------------------------------------------------------------------------
module vfcao_front import vfcao_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       voxel_valid,
	output logic       voxel_stall,
	input  voxel_t     voxel,
	input  logic       q_full,
	output push_t      q_push
);

	logic [7:0] air_code_q;
	logic [7:0] water_code_q;
	logic       is_air;
	logic       is_water;
	logic [5:0] solid_faces;
	logic [5:0] face_mask;

	// Type registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_code_q   <= 8'd0;
			water_code_q <= 8'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_AIR_TYPE:   air_code_q   <= cfg_data;
				REG_WATER_TYPE: water_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A solid voxel shows each face whose neighbor is not solid.
	always_comb begin
		for (int d = 0; d < NUM_DIRS; d++)
			solid_faces[d] = !voxel.solid_mask[NORM_BIT[d]];
	end

	// Air wins over water when both codes match; water never shows its bottom.
	always_comb begin
		is_air   = (voxel.block_type == air_code_q);
		is_water = !is_air && (voxel.block_type == water_code_q);
		if (is_air)
			face_mask = '0;
		else if (is_water)
			face_mask = voxel.air_mask & ~(6'b1 << DIR_BOTTOM);
		else
			face_mask = solid_faces;
	end

	// A voxel without faces is dropped unless it must clear the counters.
	assign voxel_stall = q_full;

	always_comb begin
		q_push.push                 = voxel_valid && !q_full &&
			((face_mask != '0) || voxel.first_of_chunk);
		q_push.entry.first_of_chunk = voxel.first_of_chunk;
		q_push.entry.pos_x          = voxel.pos_x;
		q_push.entry.pos_y          = voxel.pos_y;
		q_push.entry.pos_z          = voxel.pos_z;
		q_push.entry.block_type     = voxel.block_type;
		q_push.entry.is_water       = is_water;
		q_push.entry.face_mask      = face_mask;
		q_push.entry.solid_mask     = voxel.solid_mask;
	end

endmodule

// File: sv/vfcao_queue.sv
// ----------------------------------------------------------------------------
// Voxel queue
// Short first-in first-out buffer of classified voxels between the
// classifier and the face emitter.
// ----------------------------------------------------------------------------
`include "voxel_face_cull_ambient_occlusion_defines.svh"

module vfcao_queue import vfcao_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t q_push,
	input  logic  pop,
	output logic  full,
	output head_t q_head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full          = (count_q == CW'(DEPTH));
	assign q_head.empty  = (count_q == '0);
	assign q_head.head   = slot_q[rd_ptr_q];
	assign do_push       = q_push.push && !full;
	assign do_pop        = pop && !q_head.empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= q_push.entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	`VFCAO_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "queue count overflow")
	`VFCAO_ASSERT_IMP(a_empty_ptrs, q_head.empty, wr_ptr_q == rd_ptr_q, "empty queue ptr skew")
	`VFCAO_ASSERT_NXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1,
		"queue count did not grow")

endmodule

// File: sv/vfcao_back.sv
// ----------------------------------------------------------------------------
// Face emitter
// Walks the head voxel's visible faces one per cycle unless stalled, computes
// vertex shade codes, hands out base indices and holds the output register.
// ----------------------------------------------------------------------------
`include "voxel_face_cull_ambient_occlusion_defines.svh"

module vfcao_back import vfcao_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  head_t q_head,
	output logic  pop,
	output logic  face_valid,
	input  logic  face_stall,
	output face_t face
);

	entry_t      cur_q;
	logic        cur_valid_q;
	logic [5:0]  rem_q;
	logic [15:0] solid_cnt_q;
	logic [15:0] water_cnt_q;
	face_t       out_q;
	logic        out_valid_q;

	logic        can_emit;
	logic        emit;
	logic        done;
	logic        clr_cnt;
	logic        sel_water_top;
	logic [2:0]  sel_dir;
	logic [5:0]  rem_after;
	face_t       next_face;

	// Lowest remaining face goes first.
	always_comb begin
		sel_dir = DIR_TOP;
		for (int d = NUM_DIRS - 1; d >= 0; d--)
			if (rem_q[d])
				sel_dir = 3'(d);
	end

	assign rem_after     = rem_q & ~(6'b1 << sel_dir);
	assign can_emit      = !out_valid_q || !face_stall;
	assign emit          = cur_valid_q && (rem_q != '0) && can_emit;
	assign done          = cur_valid_q && ((rem_q == '0) || (emit && (rem_after == '0)));
	assign pop           = (!cur_valid_q || done) && !q_head.empty;
	assign clr_cnt       = pop && q_head.head.first_of_chunk;
	assign sel_water_top = cur_q.is_water && (sel_dir == DIR_TOP);

	// Face beat built from the current voxel.
	always_comb begin
		next_face.face_x         = cur_q.pos_x;
		next_face.face_y         = cur_q.pos_y;
		next_face.face_z         = cur_q.pos_z;
		next_face.face_dir       = sel_dir;
		next_face.to_water_mesh  = sel_water_top;
		next_face.use_side_color = cur_q.is_water && (sel_dir != DIR_TOP);
		next_face.face_type      = cur_q.block_type;
		next_face.shade_codes    = cur_q.is_water ? 12'd0 :
			face_shades(cur_q.solid_mask, sel_dir);
		next_face.base_index     = sel_water_top ? water_cnt_q : solid_cnt_q;
		next_face.last_face      = (rem_after == '0);
	end

	// Current voxel and its remaining faces.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			rem_q       <= q_head.head.face_mask;
		end else if (done) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (emit) begin
			rem_q <= rem_after;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_head.head;
	end

	// Index counters; a new chunk clears both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_cnt_q <= '0;
			water_cnt_q <= '0;
		end else if (clr_cnt) begin
			solid_cnt_q <= '0;
			water_cnt_q <= '0;
		end else if (emit) begin
			if (sel_water_top)
				water_cnt_q <= water_cnt_q + 16'd6;
			else
				solid_cnt_q <= solid_cnt_q + 16'd6;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!face_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= next_face;
	end

	assign face_valid = out_valid_q;
	assign face       = out_q;

	`VFCAO_ASSERT_IMP(a_rem_subset, cur_valid_q, (rem_q & ~cur_q.face_mask) == '0,
		"remaining faces outside voxel mask")
	`VFCAO_ASSERT_IMP(a_water_no_bottom, cur_valid_q && cur_q.is_water,
		!cur_q.face_mask[DIR_BOTTOM], "water voxel with bottom face")
	`VFCAO_ASSERT_NXT(a_solid_step, emit && !sel_water_top && !clr_cnt,
		solid_cnt_q == 16'($past(solid_cnt_q) + 16'd6), "solid index did not advance")
	`VFCAO_ASSERT_NXT(a_water_step, emit && sel_water_top && !clr_cnt,
		water_cnt_q == 16'($past(water_cnt_q) + 16'd6), "water index did not advance")

endmodule

// File: sv/voxel_face_cull_ambient_occlusion.sv
// ----------------------------------------------------------------------------
// Voxel face culling with vertex ambient occlusion
// Turns voxels with precomputed neighbor masks into visible faces carrying
// shade codes and base vertex indices for the solid and water meshes.
// ----------------------------------------------------------------------------
// Usage:
// The voxel channel takes one voxel per beat (voxel_valid, voxel_stall) and
// the face channel returns one face per beat (face_valid, face_stall); the
// last face of a voxel carries last_face. Air voxels and voxels with no
// visible face give no beat. Type codes are written through cfg_wr_en,
// cfg_index and cfg_data while the block is idle.
// A voxel passes through the queue, the current voxel register of the face
// emitter and the output register before its first face beat is shown. The
// face emitter produces one face per cycle while the receiver does not stall,
// and takes the next voxel as it emits the last face of the current one; a
// voxel that only clears the counters gives no face. Voxels are accepted every
// cycle while the queue of QUEUE_DEPTH entries has room.
// Reset clears the queue, the output register and both index counters and
// loads air code 0 and water code 1. When the receiver stalls, the face beat
// holds in the output register, the emitter waits and the queue fills; once
// full, voxel_stall rises.
// ----------------------------------------------------------------------------
module voxel_face_cull_ambient_occlusion import vfcao_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       voxel_valid,
	output logic       voxel_stall,
	input  voxel_t     voxel,
	output logic       face_valid,
	input  logic       face_stall,
	output face_t      face
);

	push_t q_push;
	head_t q_head;
	logic  q_full;
	logic  q_pop;

	// Classifier.
	vfcao_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.voxel_valid (voxel_valid),
		.voxel_stall (voxel_stall),
		.voxel       (voxel),
		.q_full      (q_full),
		.q_push      (q_push)
	);

	// Queue between the two halves.
	vfcao_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (q_pop),
		.full   (q_full),
		.q_head (q_head)
	);

	// Face emitter.
	vfcao_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_head     (q_head),
		.pop        (q_pop),
		.face_valid (face_valid),
		.face_stall (face_stall),
		.face       (face)
	);

endmodule
